// ----- src/track_density_accumulator_unit_macros.svh -----
// Assertion helpers for the file that checks its own logic.
`ifndef TRACK_DENSITY_ACCUMULATOR_UNIT_MACROS_SVH
`define TRACK_DENSITY_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, masked while i_rst_n is low.
`define TDACC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tdacc check failed");

// Next-cycle implication, sampled on i_clk, masked while i_rst_n is low.
`define TDACC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tdacc check failed");

`endif

// ----- src/tdacc_pkg.sv -----
`default_nettype none
package tdacc_pkg;

    localparam int AXIS_MAX    = 64;
    localparam int COUNT_BITS  = 32;

    localparam int STORE_DEPTH = AXIS_MAX * AXIS_MAX * AXIS_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int VIDX_W      = 18;
    localparam int IDX_W       = (ADDR_W > VIDX_W) ? ADDR_W : VIDX_W;
    localparam int IDX_CMP_W   = IDX_W + 1;
    localparam int AX_W        = $clog2(AXIS_MAX);
    localparam int DIM_W       = $clog2(AXIS_MAX + 1);

    localparam int DIM_REG_W   = 7;
    localparam int SIZE_W      = 16;
    localparam int COORD_W     = 24;
    localparam int QUOT_W      = COORD_W - 1;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int COUNT_OUT_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_X  = 3'd0,
        CFG_DIM_Y  = 3'd1,
        CFG_DIM_Z  = 3'd2,
        CFG_SIZE_X = 3'd3,
        CFG_SIZE_Y = 3'd4,
        CFG_SIZE_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] d);
        logic [DIM_W-1:0] res;
        if (d == '0) begin
            res = DIM_W'(1);
        end else if (32'(d) > AXIS_MAX) begin
            res = DIM_W'(AXIS_MAX);
        end else begin
            res = DIM_W'(d);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- src/tdacc_div.sv -----
`default_nettype none
module tdacc_div (
    input  logic                             i_clk,
    input  tdacc_pkg::t_div_ctrl             i_ctrl,
    input  logic [tdacc_pkg::QUOT_W-1:0]     i_dividend,
    input  logic [tdacc_pkg::SIZE_W-1:0]     i_divisor,
    output logic [tdacc_pkg::QUOT_W-1:0]     o_quot
);
    import tdacc_pkg::*;

    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_den, n_den;
    logic [QUOT_W-1:0] r_quo, n_quo;
    logic [SIZE_W:0]   trial;
    logic              qbit;

    always_comb begin
        n_rem = r_rem;
        n_den = r_den;
        n_quo = r_quo;
        trial = {r_rem, r_quo[QUOT_W-1]};
        qbit  = 1'b0;
        if (i_ctrl.load) begin
            n_rem = '0;
            n_quo = i_dividend;
            n_den = (i_divisor == '0) ? SIZE_W'(1) : i_divisor;
        end else if (i_ctrl.step) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = SIZE_W'(trial - {1'b0, r_den});
                qbit  = 1'b1;
            end else begin
                n_rem = trial[SIZE_W-1:0];
            end
            n_quo = {r_quo[QUOT_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_quot = r_quo;

endmodule
`default_nettype wire

// ----- src/track_density_accumulator_unit.sv -----
// An accumulate beat runs restoring division (one quotient bit per cycle, three axes
// side by side), then clamp, index multiply, index add, count read and count write;
// the write state waits until the output register is free, and no new beat is taken
// before the last one returns. A read beat goes to count read and the write state.
// After reset the count store's AXIS_MAX**3 (262144) entries are zeroed one entry per
// cycle, with input ready low; configuration writes are taken throughout.
`default_nettype none
`include "track_density_accumulator_unit_macros.svh"
module track_density_accumulator_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tdacc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tdacc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_operation,
    input  logic                                  i_new_track,
    input  logic signed [tdacc_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [tdacc_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [tdacc_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [tdacc_pkg::VIDX_W-1:0]          i_read_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [tdacc_pkg::VIDX_W-1:0]          o_voxel_index,
    output logic                                  o_counted,
    output logic [tdacc_pkg::COUNT_OUT_W-1:0]     o_count
);
    import tdacc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CLAMP,
        S_MUL,
        S_IDX,
        S_RD,
        S_WR
    } t_state;

    logic [DIM_REG_W-1:0] r_dim_x, r_dim_y, r_dim_z;
    logic [SIZE_W-1:0]    r_size_x, r_size_y, r_size_z;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_is_read, n_is_read;
    logic                 r_new_track, n_new_track;
    logic                 r_oob, n_oob;
    logic [AX_W-1:0]      r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic [IDX_W-1:0]     r_row, n_row, r_plane, n_plane;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [VIDX_W-1:0]    r_prev_idx, n_prev_idx;
    logic                 r_prev_valid, n_prev_valid;
    logic                 r_out_valid, n_out_valid;
    logic [VIDX_W-1:0]    r_out_index, n_out_index;
    logic                 r_out_counted, n_out_counted;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;

    logic [COUNT_BITS-1:0] r_mem [STORE_DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    t_div_ctrl            div_ctrl;
    logic [QUOT_W-1:0]    quot_x, quot_y, quot_z;
    logic [QUOT_W-1:0]    dvd_x, dvd_y, dvd_z;
    logic [DIM_W-1:0]     dim_x_eff, dim_y_eff, dim_z_eff;
    logic                 in_accept;
    logic                 wr_go;
    logic                 repeat_hit;
    logic                 hit;
    logic                 clamp_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x  <= DIM_REG_W'(64);
            r_dim_y  <= DIM_REG_W'(64);
            r_dim_z  <= DIM_REG_W'(64);
            r_size_x <= SIZE_W'(256);
            r_size_y <= SIZE_W'(256);
            r_size_z <= SIZE_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIM_X:  r_dim_x  <= i_cfg_data[DIM_REG_W-1:0];
                CFG_DIM_Y:  r_dim_y  <= i_cfg_data[DIM_REG_W-1:0];
                CFG_DIM_Z:  r_dim_z  <= i_cfg_data[DIM_REG_W-1:0];
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign dim_x_eff = eff_dim(r_dim_x);
    assign dim_y_eff = eff_dim(r_dim_y);
    assign dim_z_eff = eff_dim(r_dim_z);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign wr_go      = (r_state == S_WR) && (!r_out_valid || i_out_ready);

    assign dvd_x = i_coord_x[COORD_W-1] ? '0 : i_coord_x[QUOT_W-1:0];
    assign dvd_y = i_coord_y[COORD_W-1] ? '0 : i_coord_y[QUOT_W-1:0];
    assign dvd_z = i_coord_z[COORD_W-1] ? '0 : i_coord_z[QUOT_W-1:0];

    assign div_ctrl.load = in_accept && (i_operation == OP_ACCUM);
    assign div_ctrl.step = (r_state == S_DIV);

    tdacc_div u_div_x (
        .i_clk      (i_clk),
        .i_ctrl     (div_ctrl),
        .i_dividend (dvd_x),
        .i_divisor  (r_size_x),
        .o_quot     (quot_x)
    );

    tdacc_div u_div_y (
        .i_clk      (i_clk),
        .i_ctrl     (div_ctrl),
        .i_dividend (dvd_y),
        .i_divisor  (r_size_y),
        .o_quot     (quot_y)
    );

    tdacc_div u_div_z (
        .i_clk      (i_clk),
        .i_ctrl     (div_ctrl),
        .i_dividend (dvd_z),
        .i_divisor  (r_size_z),
        .o_quot     (quot_z)
    );

    assign repeat_hit = !r_new_track && r_prev_valid && (IDX_W'(r_prev_idx) == r_idx);
    assign hit        = !repeat_hit && !(&r_rd_data);
    assign clamp_ok   = (DIM_W'(r_px) < dim_x_eff) && (DIM_W'(r_py) < dim_y_eff)
                        && (DIM_W'(r_pz) < dim_z_eff);

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_step        = r_step;
        n_is_read     = r_is_read;
        n_new_track   = r_new_track;
        n_oob         = r_oob;
        n_px          = r_px;
        n_py          = r_py;
        n_pz          = r_pz;
        n_row         = r_row;
        n_plane       = r_plane;
        n_idx         = r_idx;
        n_addr        = r_addr;
        n_prev_idx    = r_prev_idx;
        n_prev_valid  = r_prev_valid;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_index   = r_out_index;
        n_out_counted = r_out_counted;
        n_out_count   = r_out_count;
        mem_we        = 1'b0;
        mem_waddr     = r_addr;
        mem_wdata     = r_rd_data + COUNT_BITS'(1);

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_is_read   = (i_operation == OP_READ);
                    n_new_track = i_new_track;
                    n_step      = '0;
                    if (i_operation == OP_READ) begin
                        n_idx   = IDX_W'(i_read_index);
                        n_addr  = ADDR_W'(i_read_index);
                        n_oob   = IDX_CMP_W'(i_read_index) >= IDX_CMP_W'(STORE_DEPTH);
                        n_state = S_RD;
                    end else begin
                        n_oob   = 1'b0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_px = (quot_x >= QUOT_W'(dim_x_eff)) ? AX_W'(dim_x_eff - DIM_W'(1))
                                                      : AX_W'(quot_x);
                n_py = (quot_y >= QUOT_W'(dim_y_eff)) ? AX_W'(dim_y_eff - DIM_W'(1))
                                                      : AX_W'(quot_y);
                n_pz = (quot_z >= QUOT_W'(dim_z_eff)) ? AX_W'(dim_z_eff - DIM_W'(1))
                                                      : AX_W'(quot_z);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_row   = IDX_W'(r_py) * IDX_W'(dim_x_eff);
                n_plane = IDX_W'(dim_x_eff) * IDX_W'(dim_y_eff);
                n_state = S_IDX;
            end
            S_IDX: begin
                n_idx   = IDX_W'(r_px) + r_row + IDX_W'(r_pz) * r_plane;
                n_addr  = ADDR_W'(n_idx);
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (wr_go) begin
                    n_out_valid = 1'b1;
                    n_out_index = VIDX_W'(r_idx);
                    n_state     = S_IDLE;
                    if (r_is_read) begin
                        n_out_counted = 1'b0;
                        n_out_count   = r_oob ? '0 : COUNT_OUT_W'(r_rd_data);
                    end else begin
                        mem_we        = hit;
                        n_out_counted = hit;
                        n_out_count   = hit ? COUNT_OUT_W'(mem_wdata)
                                            : COUNT_OUT_W'(r_rd_data);
                        n_prev_idx    = VIDX_W'(r_idx);
                        n_prev_valid  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_step        <= n_step;
        r_is_read     <= n_is_read;
        r_new_track   <= n_new_track;
        r_oob         <= n_oob;
        r_px          <= n_px;
        r_py          <= n_py;
        r_pz          <= n_pz;
        r_row         <= n_row;
        r_plane       <= n_plane;
        r_idx         <= n_idx;
        r_addr        <= n_addr;
        r_prev_idx    <= n_prev_idx;
        r_out_index   <= n_out_index;
        r_out_counted <= n_out_counted;
        r_out_count   <= n_out_count;
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_prev_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_prev_valid <= n_prev_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    assign o_out_valid   = r_out_valid;
    assign o_voxel_index = r_out_index;
    assign o_counted     = r_out_counted;
    assign o_count       = r_out_count;

    `TDACC_ASSERT_IMP(a_counted_nonzero, o_out_valid && o_counted, o_count != '0)
    `TDACC_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `TDACC_ASSERT_IMP(a_clamp_in_range, r_state == S_MUL, clamp_ok)
    `TDACC_ASSERT_NXT(a_read_not_counted, wr_go && r_is_read, o_out_valid && !o_counted)

endmodule
`default_nettype wire
